[rtl/trapezoid_motion_profile_top_defines.svh]
// Assertion macros for the profile generator RTL.
`ifndef TRAPEZOID_MOTION_PROFILE_TOP_DEFINES_SVH
`define TRAPEZOID_MOTION_PROFILE_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define TMP_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define TMP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/tmp_pkg.sv]
// Types, constants and helpers of the trapezoidal profile generator.
`default_nettype none
package tmp_pkg;

    localparam int FRAC_BITS = 24;
    // one millisecond in fixed point, rounded
    localparam int DT_Q = ((1 << FRAC_BITS) + 500) / 1000;

    localparam logic [5:0] MUL_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST = 6'd62;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0]
    {
        OP_TICK     = 2'd0,
        OP_ADD_DIST = 2'd1,
        OP_ADD_HEAD = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [2:0]
    {
        REG_LINEAR_ACCEL = 3'd0,
        REG_TURN_ACCEL   = 3'd1,
        REG_LINEAR_LIMIT = 3'd2,
        REG_TURN_LIMIT   = 3'd3,
        REG_END_SPEED    = 3'd4,
        REG_GO_BACKWARD  = 3'd5,
        REG_TURN_CW      = 3'd6,
        REG_APPROACH     = 3'd7
    } reg_index_t;

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef enum logic [3:0]
    {
        PH_VV   = 4'd0,
        PH_FF   = 4'd1,
        PH_LDIV = 4'd2,
        PH_WW   = 4'd3,
        PH_RDIV = 4'd4,
        PH_LDT  = 4'd5,
        PH_RDT  = 4'd6,
        PH_PD   = 4'd7,
        PH_PH   = 4'd8
    } phase_t;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        abs32 = x[31] ? (32'd0 - x) : x;
    endfunction

    // quotient magnitude to a saturated signed 32-bit braking distance
    function automatic logic [31:0] sat_quot(input logic [62:0] q, input logic neg);
        logic [31:0] r;
        if (!neg)
        begin
            r = (q > 63'(SAT_MAX)) ? SAT_MAX : q[31:0];
        end
        else
        begin
            r = (q > 63'(SAT_MIN)) ? SAT_MIN : (32'd0 - q[31:0]);
        end
        sat_quot = r;
    endfunction

    function automatic logic [31:0] clamp_dir(input logic signed [33:0] x,
                                              input logic neg_side,
                                              input logic [30:0] lim);
        logic signed [33:0] l;
        logic signed [33:0] r;
        l = $signed({3'b000, lim});
        if (!neg_side)
        begin
            if (x < 0)
                r = '0;
            else if (x > l)
                r = l;
            else
                r = x;
        end
        else
        begin
            if (x > 0)
                r = '0;
            else if (x < -l)
                r = -l;
            else
                r = x;
        end
        clamp_dir = r[31:0];
    endfunction

endpackage
`default_nettype wire

[rtl/trapezoid_motion_profile_top.sv]
// Two-axis trapezoidal velocity profile generator, top level.
//
// Requests enter on the s_ stream: s_tuser carries the opcode (tick, add to
// distance goal, add to heading goal), s_tdata the signed Q8.24 delta.
// Each request yields one result on the m_ stream: both speeds, both planned
// positions and both goals, taken from the state after the request.
// One request is in work at a time; s_tready is high only when idle.
// A tick runs on a radix-2 shift-add multiplier and a restoring divider,
// one bit per cycle: seven 32-step products and two 63-step divisions;
// the division for an acceleration register that is zero is skipped.
// Goal additions go straight from idle to the output state.
// The output register holds a result until m_tready; a new request can be
// accepted meanwhile and its result waits until the register frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are meant to be issued only while idle.
// Reset clears goals, speeds, positions, end speed and flags to zero, sets accelerations
// and limits to 1.0 and empties the output register; the datapath registers are not reset.
`default_nettype none
`include "trapezoid_motion_profile_top_defines.svh"
module trapezoid_motion_profile_top
    import tmp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // delta
    input  wire logic [1:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // speed_now, turn_rate_now, distance_now, heading_now,
    // distance_goal_now, heading_goal_now
    output logic [191:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);

    // configuration
    logic [30:0] lin_acc_reg, turn_acc_reg, lin_lim_reg, turn_lim_reg, end_speed_reg;
    logic        backward_reg, clockwise_reg, approach_reg;

    // profile state
    logic [31:0] goal_d_reg, goal_d_next, goal_h_reg, goal_h_next;
    logic [31:0] v_reg, v_next, w_reg, w_next;
    logic [31:0] pd_reg, pd_next, ph_reg, ph_next;

    // control
    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // shared multiply / divide datapath
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;   // divisor during a division
    logic [63:0] acc_reg, acc_next;         // dividend / quotient during a division
    logic [32:0] rem_reg, rem_next;
    logic [63:0] sq_reg, sq_next;
    logic        neg_reg, neg_next;
    logic [31:0] dl_reg, dl_next, dr_reg, dr_next;
    logic [31:0] adt_l_reg, adt_l_next, adt_r_reg, adt_r_next;
    logic [191:0] out_reg, out_next;

    // comb helpers
    logic [63:0] acc_mul;
    logic [31:0] prod_dt;
    logic [32:0] div_sh, div_rem;
    logic        div_ge;
    logic [62:0] div_q;
    logic signed [63:0] num_s;
    logic [63:0] num_mag;
    logic        mul_go, div_go;
    logic [31:0] mul_a, mul_b, div_d;
    logic [62:0] div_n;
    phase_t      mul_ph, div_ph;
    logic signed [33:0] pd34, ph34, gd34, gh34, dl34, dr34, v34, w34, adl34, adr34;
    logic signed [33:0] vs34, ws34;
    logic        lin_up, rot_up;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        goal_d_next   = goal_d_reg;
        goal_h_next   = goal_h_reg;
        v_next        = v_reg;
        w_next        = w_reg;
        pd_next       = pd_reg;
        ph_next       = ph_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        sq_next       = sq_reg;
        neg_next      = neg_reg;
        dl_next       = dl_reg;
        dr_next       = dr_reg;
        adt_l_next    = adt_l_reg;
        adt_r_next    = adt_r_reg;
        out_next      = out_reg;

        mul_go = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        mul_ph = PH_VV;
        div_go = 1'b0;
        div_n  = '0;
        div_d  = '0;
        div_ph = PH_LDIV;

        acc_mul = acc_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
        prod_dt = 32'(acc_mul >> FRAC_BITS);
        div_sh  = {rem_reg[31:0], acc_reg[62]};
        div_ge  = (div_sh >= {1'b0, mplier_reg});
        div_rem = div_ge ? (div_sh - {1'b0, mplier_reg}) : div_sh;
        div_q   = {acc_reg[61:0], div_ge};
        num_s   = $signed(sq_reg - acc_mul);
        num_mag = num_s[63] ? (64'd0 - num_s) : num_s;

        pd34  = $signed({{2{pd_reg[31]}}, pd_reg});
        ph34  = $signed({{2{ph_reg[31]}}, ph_reg});
        gd34  = $signed({{2{goal_d_reg[31]}}, goal_d_reg});
        gh34  = $signed({{2{goal_h_reg[31]}}, goal_h_reg});
        dl34  = $signed({{2{dl_reg[31]}}, dl_reg});
        dr34  = $signed({{2{dr_reg[31]}}, dr_reg});
        v34   = $signed({{2{v_reg[31]}}, v_reg});
        w34   = $signed({{2{w_reg[31]}}, w_reg});
        adl34 = $signed({2'b00, adt_l_reg});
        adr34 = $signed({2'b00, adt_r_reg});

        if (!approach_reg)
            lin_up = !backward_reg;
        else if (!backward_reg)
            lin_up = (pd34 < gd34 - dl34);
        else
            lin_up = !(pd34 > gd34 + dl34);
        if (!clockwise_reg)
            rot_up = (ph34 < gh34 - dr34);
        else
            rot_up = !(ph34 > gh34 + dr34);
        vs34 = lin_up ? (v34 + adl34) : (v34 - adl34);
        ws34 = rot_up ? (w34 + adr34) : (w34 - adr34);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (opcode_t'(s_tuser))
                        OP_TICK:
                        begin
                            mul_go = 1'b1;
                            mul_a  = abs32(v_reg);
                            mul_b  = abs32(v_reg);
                            mul_ph = PH_VV;
                        end
                        OP_ADD_DIST:
                        begin
                            goal_d_next = goal_d_reg + s_tdata;
                            state_next  = ST_OUT;
                        end
                        OP_ADD_HEAD:
                        begin
                            goal_h_next = goal_h_reg + s_tdata;
                            state_next  = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                acc_next    = acc_mul;
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    case (phase_reg)
                        PH_VV:
                        begin
                            sq_next = acc_mul;
                            mul_go  = 1'b1;
                            mul_a   = {1'b0, end_speed_reg};
                            mul_b   = {1'b0, end_speed_reg};
                            mul_ph  = PH_FF;
                        end
                        PH_FF:
                        begin
                            neg_next = num_s[63];
                            if (lin_acc_reg == '0)
                            begin
                                // zero acceleration: saturate by sign of v^2-vf^2
                                if (num_s == 0)
                                    dl_next = '0;
                                else
                                    dl_next = num_s[63] ? SAT_MIN : SAT_MAX;
                                mul_go = 1'b1;
                                mul_a  = abs32(w_reg);
                                mul_b  = abs32(w_reg);
                                mul_ph = PH_WW;
                            end
                            else
                            begin
                                div_go = 1'b1;
                                div_n  = num_mag[62:0];
                                div_d  = {lin_acc_reg, 1'b0};
                                div_ph = PH_LDIV;
                            end
                        end
                        PH_WW:
                        begin
                            neg_next = 1'b0;
                            if (turn_acc_reg == '0)
                            begin
                                dr_next = (acc_mul == 64'd0) ? 32'd0 : SAT_MAX;
                                mul_go  = 1'b1;
                                mul_a   = {1'b0, lin_acc_reg};
                                mul_b   = 32'(DT_Q);
                                mul_ph  = PH_LDT;
                            end
                            else
                            begin
                                div_go = 1'b1;
                                div_n  = acc_mul[62:0];
                                div_d  = {turn_acc_reg, 1'b0};
                                div_ph = PH_RDIV;
                            end
                        end
                        PH_LDT:
                        begin
                            adt_l_next = prod_dt;
                            mul_go     = 1'b1;
                            mul_a      = {1'b0, turn_acc_reg};
                            mul_b      = 32'(DT_Q);
                            mul_ph     = PH_RDT;
                        end
                        PH_RDT:
                        begin
                            adt_r_next = prod_dt;
                            state_next = ST_UPD;
                        end
                        PH_PD:
                        begin
                            pd_next = pd_reg + (v_reg[31] ? (32'd0 - prod_dt) : prod_dt);
                            mul_go  = 1'b1;
                            mul_a   = abs32(w_reg);
                            mul_b   = 32'(DT_Q);
                            mul_ph  = PH_PH;
                        end
                        PH_PH:
                        begin
                            ph_next    = ph_reg + (w_reg[31] ? (32'd0 - prod_dt) : prod_dt);
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next = div_rem;
                acc_next = {1'b0, div_q};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    if (phase_reg == PH_LDIV)
                    begin
                        dl_next = sat_quot(div_q, neg_reg);
                        mul_go  = 1'b1;
                        mul_a   = abs32(w_reg);
                        mul_b   = abs32(w_reg);
                        mul_ph  = PH_WW;
                    end
                    else
                    begin
                        dr_next = sat_quot(div_q, 1'b0);
                        mul_go  = 1'b1;
                        mul_a   = {1'b0, lin_acc_reg};
                        mul_b   = 32'(DT_Q);
                        mul_ph  = PH_LDT;
                    end
                end
            end
            ST_UPD:
            begin
                v_next = clamp_dir(vs34, backward_reg, lin_lim_reg);
                w_next = clamp_dir(ws34, clockwise_reg, turn_lim_reg);
                mul_go = 1'b1;
                mul_a  = abs32(clamp_dir(vs34, backward_reg, lin_lim_reg));
                mul_b  = 32'(DT_Q);
                mul_ph = PH_PD;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next   = {goal_h_reg, goal_d_reg, ph_reg, pd_reg, w_reg, v_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mul_go)
        begin
            state_next  = ST_MUL;
            phase_next  = mul_ph;
            cnt_next    = '0;
            mcand_next  = {32'd0, mul_a};
            mplier_next = mul_b;
            acc_next    = '0;
        end
        if (div_go)
        begin
            state_next  = ST_DIV;
            phase_next  = div_ph;
            cnt_next    = '0;
            mplier_next = div_d;
            acc_next    = {1'b0, div_n};
            rem_next    = '0;
        end

        // output register: load on leaving ST_OUT, drain on m_tready
        if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready))
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_acc_reg   <= 31'(1 << FRAC_BITS);
            turn_acc_reg  <= 31'(1 << FRAC_BITS);
            lin_lim_reg   <= 31'(1 << FRAC_BITS);
            turn_lim_reg  <= 31'(1 << FRAC_BITS);
            end_speed_reg <= '0;
            backward_reg  <= 1'b0;
            clockwise_reg <= 1'b0;
            approach_reg  <= 1'b0;
            goal_d_reg    <= '0;
            goal_h_reg    <= '0;
            v_reg         <= '0;
            w_reg         <= '0;
            pd_reg        <= '0;
            ph_reg        <= '0;
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_VV;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_LINEAR_ACCEL: lin_acc_reg   <= cfg_data;
                    REG_TURN_ACCEL:   turn_acc_reg  <= cfg_data;
                    REG_LINEAR_LIMIT: lin_lim_reg   <= cfg_data;
                    REG_TURN_LIMIT:   turn_lim_reg  <= cfg_data;
                    REG_END_SPEED:    end_speed_reg <= cfg_data;
                    REG_GO_BACKWARD:  backward_reg  <= cfg_data[0];
                    REG_TURN_CW:      clockwise_reg <= cfg_data[0];
                    REG_APPROACH:     approach_reg  <= cfg_data[0];
                    default:          approach_reg  <= approach_reg;
                endcase
            end
            goal_d_reg   <= goal_d_next;
            goal_h_reg   <= goal_h_next;
            v_reg        <= v_next;
            w_reg        <= w_next;
            pd_reg       <= pd_next;
            ph_reg       <= ph_next;
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        sq_reg     <= sq_next;
        neg_reg    <= neg_next;
        dl_reg     <= dl_next;
        dr_reg     <= dr_next;
        adt_l_reg  <= adt_l_next;
        adt_r_reg  <= adt_r_next;
        out_reg    <= out_next;
    end

    `TMP_ASSERT_SAME(a_mul_count, state_reg == ST_MUL, cnt_reg <= MUL_LAST,
        "multiplier ran past its last step")
    `TMP_ASSERT_SAME(a_div_rem, state_reg == ST_DIV, rem_reg < 33'(mplier_reg),
        "divider remainder not below divisor")
    `TMP_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != ST_IDLE,
        "request accepted but sequencer stayed idle")
    `TMP_ASSERT_SAME(a_out_load, $rose(m_tvalid_reg), $past(state_reg == ST_OUT),
        "result presented without passing the output state")

endmodule
`default_nettype wire
